### rtl/core/pvft_pkg.sv
// Shared types, constants and the arctangent table of the pose tracker.
`default_nettype none
package pvft_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;

  // Serial multiplier operand widths, divider widths, angle and CORDIC widths.
  localparam int MA_W  = 33;
  localparam int MB_W  = 32;
  localparam int P_W   = MA_W + MB_W;
  localparam int DN_W  = 66;
  localparam int DD_W  = 33;
  localparam int ANG_W = 48;
  localparam int CX_W  = 34;
  localparam int CNT_W = 7;

  localparam logic [63:0] VAR_RESET_W = 64'd10000 << FRAC_BITS;
  localparam logic [31:0] VAR_RESET   = (VAR_RESET_W > 64'hFFFF_FFFF) ?
                                        32'hFFFF_FFFF : VAR_RESET_W[31:0];
  localparam logic [15:0] BASE_RESET  = 16'd1000;

  localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CX_W-1:0] UNIT_Q30    = 34'sd1073741824;
  localparam logic [MB_W-1:0] DEG_TO_RAD    = 32'd18740330;
  localparam logic [MB_W-1:0] RAD_TO_DEG_MS = 32'd246083499;

  localparam logic [DD_W-1:0] FULL_DEG     = DD_W'(64'd360 << FRAC_BITS);
  localparam logic [DD_W-1:0] HALF_DEG     = DD_W'(64'd180 << FRAC_BITS);
  localparam logic [DD_W-1:0] QUARTER_DEG  = DD_W'(64'd90 << FRAC_BITS);
  localparam logic [DD_W-1:0] STRAIGHT_DIV = DD_W'(64'd2000 << (30 - FRAC_BITS));
  localparam int ARC_SHIFT = 31 - FRAC_BITS;
  localparam int DH_SHIFT  = 32 - FRAC_BITS;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_F_AXIS,
    ST_F_DIV1,
    ST_F_MEAN,
    ST_F_DIV2,
    ST_F_VAR,
    ST_SC_MOD,
    ST_SC_FOLD,
    ST_SC_Z,
    ST_SC_ROT,
    ST_SC_END,
    ST_A_K,
    ST_A_DHD,
    ST_A_DH,
    ST_T_LATM,
    ST_T_LATD,
    ST_T_LAT,
    ST_T_LOND,
    ST_T_LON,
    ST_OUT
  } pvft_state_t;

  typedef struct packed {
    logic               func;
    logic signed [31:0] meas_lat;
    logic signed [31:0] meas_lon;
    logic signed [31:0] meas_heading;
    logic [31:0]        meas_lat_var;
    logic [31:0]        meas_lon_var;
    logic [31:0]        meas_heading_var;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [15:0]        duration_ms;
  } pvft_in_t;

  typedef struct packed {
    logic signed [31:0] est_lat;
    logic signed [31:0] est_lon;
    logic signed [31:0] est_heading;
    logic [31:0]        est_lat_var;
    logic [31:0]        est_lon_var;
    logic [31:0]        est_heading_var;
  } pvft_out_t;

  // atan(2^-i) in Q30 radians
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021687;
      5'd5:  v = 32'd33543516;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048576;
      5'd11: v = 32'd524288;
      5'd12: v = 32'd262144;
      5'd13: v = 32'd131072;
      5'd14: v = 32'd65536;
      5'd15: v = 32'd32768;
      5'd16: v = 32'd16384;
      5'd17: v = 32'd8192;
      5'd18: v = 32'd4096;
      5'd19: v = 32'd2048;
      5'd20: v = 32'd1024;
      5'd21: v = 32'd512;
      5'd22: v = 32'd256;
      5'd23: v = 32'd128;
      5'd24: v = 32'd64;
      5'd25: v = 32'd32;
      5'd26: v = 32'd16;
      5'd27: v = 32'd8;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/core/pose_variance_fusion_tracker.sv
// Pose tracker top level: inverse-variance fusion and differential-drive dead reckoning.
// Throughput: one transaction at a time; the next is taken once the result is in the
//   output register. Cost is set by the 66-step radix-2 divider and 32-step
//   shift-add multiplier, one bit per cycle, shared by every multiply and divide.
// Reset (rst, synchronous, active high): means 0, variances 10000.0, baseline 1000 mm, idle.
`default_nettype none
module pose_variance_fusion_tracker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pvft_pkg::pvft_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pvft_pkg::pvft_out_t  out_data,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data
);
  import pvft_pkg::*;

  localparam logic signed [CX_W-1:0] FULL_S    = signed'({1'b0, FULL_DEG});
  localparam logic signed [CX_W-1:0] HALF_S    = signed'({1'b0, HALF_DEG});
  localparam logic signed [CX_W-1:0] QUARTER_S = signed'({1'b0, QUARTER_DEG});
  localparam logic [P_W-1:0]  Z_HALF  = P_W'(1) << (FRAC_BITS - 1);
  localparam logic [DN_W-1:0] DH_HALF = DN_W'(1) << (DH_SHIFT - 1);

  // ---------------------------------------------------------------------------
  // Saturation and clamp helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] f_sat32(input logic signed [48:0] v);
    logic signed [31:0] res;
    if (v > 49'sd2147483647) res = 32'sh7FFF_FFFF;
    else if (v < -49'sd2147483648) res = 32'sh8000_0000;
    else res = 32'(v);
    return res;
  endfunction

  // rounded magnitude plus sign back to a saturated signed 32-bit value
  function automatic logic signed [31:0] f_from_mag(input logic [DN_W-1:0] mag,
                                                     input logic neg);
    logic signed [31:0] res;
    if (neg) begin
      if (mag >= DN_W'(64'h8000_0000)) res = 32'sh8000_0000;
      else res = -signed'(mag[31:0]);
    end else begin
      if (mag > DN_W'(64'h7FFF_FFFF)) res = 32'sh7FFF_FFFF;
      else res = signed'(mag[31:0]);
    end
    return res;
  endfunction

  function automatic logic signed [31:0] f_clamp(input logic signed [CX_W-1:0] v);
    logic signed [31:0] res;
    if (v > UNIT_Q30) res = 32'(UNIT_Q30);
    else if (v < -UNIT_Q30) res = 32'(-UNIT_Q30);
    else res = 32'(v);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  pvft_state_t state, state_next;
  pvft_state_t ret, ret_next;

  pvft_in_t           item;
  logic [15:0]        baseline;
  logic signed [31:0] mean [3];
  logic [31:0]        variance [3];
  logic [1:0]         ax;
  logic [DD_W-1:0]    den;
  logic               dneg;

  // trig / motion working set
  logic signed [ANG_W-1:0] ang;
  logic signed [ANG_W-1:0] dh;
  logic                    phase;     // 0: start heading, 1: end heading
  logic                    zneg;
  logic                    sc_neg;
  logic signed [CX_W-1:0]  cx, cy, cz;
  logic signed [31:0]      c0, s0;
  logic signed [32:0]      tcos, tsin;
  logic [DD_W-1:0]         sdiv;
  logic                    aneg;
  logic [31:0]             amag;
  logic signed [31:0]      dlat;

  // shared serial multiplier and divider
  logic [MA_W-1:0]  mul_a;
  logic [MA_W-1:0]  mul_hi;
  logic [MB_W-1:0]  mul_lo;
  logic [DN_W-1:0]  div_num;
  logic [DD_W-1:0]  div_rem;
  logic [DD_W-1:0]  div_den;
  logic [CNT_W-1:0] cnt;

  // issue controls from the sequencer
  logic             mul_go, div_go;
  logic [MA_W-1:0]  mul_a_in;
  logic [MB_W-1:0]  mul_b_in;
  logic [DN_W-1:0]  div_n_in;
  logic [DD_W-1:0]  div_d_in;

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------
  logic [P_W-1:0]      product;
  logic [MA_W:0]       msum;
  logic [DD_W:0]       dtrial;
  logic                dge;

  logic signed [16:0]  sum, diff;
  logic [16:0]         sum_mag, diff_mag;
  logic [15:0]         base_eff;

  logic signed [31:0]  cur_mean, cur_m;
  logic [31:0]         cur_var, cur_vm;
  logic [DD_W-1:0]     den_c;
  logic signed [32:0]  d_c;
  logic [32:0]         d_mag;

  logic [ANG_W-1:0]    ang_mag;
  logic [DD_W-1:0]     r_pos;
  logic signed [CX_W-1:0] a0, a1;
  logic                fold_neg;
  logic [MA_W-1:0]     a_mag;
  logic [P_W-1:0]      z_sum;
  logic [CX_W-1:0]     z_mag;
  logic signed [CX_W-1:0] cz_in;

  logic signed [CX_W-1:0] xs, ys, at;
  logic signed [31:0]  sc_c, sc_s;
  logic [DN_W-1:0]     dq;
  logic signed [ANG_W-1:0] dh_c;
  logic [31:0]         tcos_mag, tsin_mag;
  logic signed [31:0]  dlon_c;

  assign product = {mul_hi, mul_lo};
  assign msum    = {1'b0, mul_hi} + (mul_lo[0] ? {1'b0, mul_a} : '0);
  assign dtrial  = {div_rem, div_num[DN_W-1]};
  assign dge     = dtrial >= {1'b0, div_den};

  assign sum      = {item.right_speed[15], item.right_speed}
                  + {item.left_speed[15], item.left_speed};
  assign diff     = {item.right_speed[15], item.right_speed}
                  - {item.left_speed[15], item.left_speed};
  assign sum_mag  = sum[16] ? 17'(-sum) : 17'(sum);
  assign diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
  assign base_eff = (baseline == '0) ? 16'd1 : baseline;

  // axis selection for the fusion steps
  always_comb begin
    case (ax)
      2'd0: begin
        cur_m  = item.meas_lat;
        cur_vm = item.meas_lat_var;
      end
      2'd1: begin
        cur_m  = item.meas_lon;
        cur_vm = item.meas_lon_var;
      end
      default: begin
        cur_m  = item.meas_heading;
        cur_vm = item.meas_heading_var;
      end
    endcase
  end

  assign cur_mean = mean[ax];
  assign cur_var  = variance[ax];
  assign den_c    = {1'b0, cur_var} + {1'b0, cur_vm};
  assign d_c      = {cur_m[31], cur_m} - {cur_mean[31], cur_mean};
  assign d_mag    = d_c[32] ? 33'(-d_c) : 33'(d_c);

  // angle reduction: remainder of |angle| mod 360, fixed for sign, folded to +-90
  assign ang_mag = ang[ANG_W-1] ? ANG_W'(-ang) : ANG_W'(ang);
  assign r_pos   = (ang[ANG_W-1] && div_rem != '0) ? FULL_DEG - div_rem : div_rem;
  assign a0      = (r_pos >= HALF_DEG) ? signed'({1'b0, r_pos}) - FULL_S
                                       : signed'({1'b0, r_pos});
  always_comb begin
    if (a0 > QUARTER_S) begin
      a1       = a0 - HALF_S;
      fold_neg = 1'b1;
    end else if (a0 < -QUARTER_S) begin
      a1       = a0 + HALF_S;
      fold_neg = 1'b1;
    end else begin
      a1       = a0;
      fold_neg = 1'b0;
    end
  end
  assign a_mag = a1[CX_W-1] ? MA_W'(-a1) : MA_W'(a1);

  // degrees to Q30 radians, rounded in magnitude
  assign z_sum = product + Z_HALF;
  assign z_mag = CX_W'(z_sum >> FRAC_BITS);
  assign cz_in = zneg ? -signed'(z_mag) : signed'(z_mag);

  // CORDIC rotation step
  assign xs = cx >>> cnt[4:0];
  assign ys = cy >>> cnt[4:0];
  assign at = signed'(CX_W'(atan_q30(cnt[4:0])));

  assign sc_c = sc_neg ? -f_clamp(cx) : f_clamp(cx);
  assign sc_s = sc_neg ? -f_clamp(cy) : f_clamp(cy);

  // heading change of an arc, rounded from the Q32 rate product
  assign dq   = div_num + DH_HALF;
  assign dh_c = diff[16] ? -signed'(ANG_W'(dq >> DH_SHIFT))
                         : signed'(ANG_W'(dq >> DH_SHIFT));

  assign tcos_mag = tcos[32] ? 32'(-tcos) : 32'(tcos);
  assign tsin_mag = tsin[32] ? 32'(-tsin) : 32'(tsin);
  assign dlon_c   = f_from_mag(div_num, aneg ^ tsin[32]);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    mul_go     = 1'b0;
    div_go     = 1'b0;
    mul_a_in   = '0;
    mul_b_in   = '0;
    div_n_in   = '0;
    div_d_in   = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = in_data.func ? ST_SC_MOD : ST_F_AXIS;
      end
      ST_MUL: begin
        if (cnt == CNT_W'(MB_W - 1)) state_next = ret;
      end
      ST_DIV: begin
        if (cnt == CNT_W'(DN_W - 1)) state_next = ret;
      end
      ST_F_AXIS: begin
        if (den_c == '0) begin
          state_next = (ax == 2'd2) ? ST_OUT : ST_F_AXIS;
        end else begin
          mul_go   = 1'b1;
          mul_a_in = d_mag;
          mul_b_in = cur_var;
          ret_next = ST_F_DIV1;
        end
      end
      ST_F_DIV1: begin
        div_go   = 1'b1;
        div_n_in = DN_W'(product) + DN_W'(den >> 1);
        div_d_in = den;
        ret_next = ST_F_MEAN;
      end
      ST_F_MEAN: begin
        mul_go   = 1'b1;
        mul_a_in = MA_W'(cur_var);
        mul_b_in = cur_vm;
        ret_next = ST_F_DIV2;
      end
      ST_F_DIV2: begin
        div_go   = 1'b1;
        div_n_in = DN_W'(product) + DN_W'(den >> 1);
        div_d_in = den;
        ret_next = ST_F_VAR;
      end
      ST_F_VAR: begin
        state_next = (ax == 2'd2) ? ST_OUT : ST_F_AXIS;
      end
      ST_SC_MOD: begin
        div_go   = 1'b1;
        div_n_in = DN_W'(ang_mag);
        div_d_in = FULL_DEG;
        ret_next = ST_SC_FOLD;
      end
      ST_SC_FOLD: begin
        mul_go   = 1'b1;
        mul_a_in = a_mag;
        mul_b_in = DEG_TO_RAD;
        ret_next = ST_SC_Z;
      end
      ST_SC_Z: begin
        state_next = ST_SC_ROT;
      end
      ST_SC_ROT: begin
        if (cnt == CNT_W'(CORDIC_STEPS - 1)) state_next = ST_SC_END;
      end
      ST_SC_END: begin
        mul_go = 1'b1;
        if (phase) begin
          mul_a_in = MA_W'(sum_mag);
          mul_b_in = MB_W'(base_eff);
          ret_next = ST_T_LATM;
        end else if (diff == '0) begin
          mul_a_in = MA_W'(sum_mag);
          mul_b_in = MB_W'(item.duration_ms);
          ret_next = ST_T_LATM;
        end else begin
          mul_a_in = MA_W'(diff_mag);
          mul_b_in = MB_W'(item.duration_ms);
          ret_next = ST_A_K;
        end
      end
      ST_A_K: begin
        mul_go   = 1'b1;
        mul_a_in = product[MA_W-1:0];
        mul_b_in = RAD_TO_DEG_MS;
        ret_next = ST_A_DHD;
      end
      ST_A_DHD: begin
        div_go   = 1'b1;
        div_n_in = DN_W'(product) + DN_W'(base_eff >> 1);
        div_d_in = DD_W'(base_eff);
        ret_next = ST_A_DH;
      end
      ST_A_DH: begin
        state_next = ST_SC_MOD;
      end
      ST_T_LATM: begin
        mul_go   = 1'b1;
        mul_a_in = MA_W'(product[31:0]);
        mul_b_in = tcos_mag;
        ret_next = ST_T_LATD;
      end
      ST_T_LATD: begin
        div_go   = 1'b1;
        div_n_in = DN_W'(product) + DN_W'(sdiv >> 1);
        div_d_in = sdiv;
        ret_next = ST_T_LAT;
      end
      ST_T_LAT: begin
        mul_go   = 1'b1;
        mul_a_in = MA_W'(amag);
        mul_b_in = tsin_mag;
        ret_next = ST_T_LOND;
      end
      ST_T_LOND: begin
        div_go   = 1'b1;
        div_n_in = DN_W'(product) + DN_W'(sdiv >> 1);
        div_d_in = sdiv;
        ret_next = ST_T_LON;
      end
      ST_T_LON: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (mul_go) state_next = ST_MUL;
    if (div_go) state_next = ST_DIV;
  end

  assign in_stall = (state != ST_IDLE);

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline <= BASE_RESET;
      for (int i = 0; i < 3; i++) begin
        mean[i]     <= '0;
        variance[i] <= VAR_RESET;
      end
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) baseline <= cfg_data;

      // output register: loads when the sequencer finishes, drains on no stall
      if (state == ST_OUT && (!out_valid || !out_stall)) begin
        out_valid                <= 1'b1;
        out_data.est_lat         <= mean[0];
        out_data.est_lon         <= mean[1];
        out_data.est_heading     <= mean[2];
        out_data.est_lat_var     <= variance[0];
        out_data.est_lon_var     <= variance[1];
        out_data.est_heading_var <= variance[2];
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            ax    <= 2'd0;
            phase <= 1'b0;
            dh    <= '0;
            ang   <= ANG_W'(mean[2]);
          end
        end
        ST_MUL: begin
          mul_hi <= msum[MA_W:1];
          mul_lo <= {msum[0], mul_lo[MB_W-1:1]};
          cnt    <= cnt + 1'b1;
        end
        ST_DIV: begin
          div_rem <= dge ? DD_W'(dtrial - {1'b0, div_den}) : dtrial[DD_W-1:0];
          div_num <= {div_num[DN_W-2:0], dge};
          cnt     <= cnt + 1'b1;
        end
        ST_F_AXIS: begin
          den  <= den_c;
          dneg <= d_c[32];
          if (den_c == '0 && ax != 2'd2) ax <= ax + 1'b1;
        end
        ST_F_MEAN: begin
          // move from the old mean toward the measurement by the rounded step
          if (dneg)
            mean[ax] <= f_sat32(49'(cur_mean) - signed'(49'(div_num[32:0])));
          else
            mean[ax] <= f_sat32(49'(cur_mean) + signed'(49'(div_num[32:0])));
        end
        ST_F_VAR: begin
          variance[ax] <= div_num[31:0];
          if (ax != 2'd2) ax <= ax + 1'b1;
        end
        ST_SC_FOLD: begin
          zneg   <= a1[CX_W-1];
          sc_neg <= fold_neg;
        end
        ST_SC_Z: begin
          cx  <= CORDIC_GAIN;
          cy  <= '0;
          cz  <= cz_in;
          cnt <= '0;
        end
        ST_SC_ROT: begin
          if (!cz[CX_W-1]) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - at;
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + at;
          end
          cnt <= cnt + 1'b1;
        end
        ST_SC_END: begin
          if (phase) begin
            // arc: chord terms over the turn, radius scale folded into the divisor
            tcos <= {c0[31], c0} - {sc_c[31], sc_c};
            tsin <= {sc_s[31], sc_s} - {s0[31], s0};
            sdiv <= DD_W'(diff_mag) << ARC_SHIFT;
            aneg <= sum[16] ^ diff[16];
          end else begin
            c0 <= sc_c;
            s0 <= sc_s;
            if (diff == '0) begin
              tcos <= {sc_c[31], sc_c};
              tsin <= {sc_s[31], sc_s};
              sdiv <= STRAIGHT_DIV;
              aneg <= sum[16];
            end
          end
        end
        ST_A_DH: begin
          dh    <= dh_c;
          ang   <= ANG_W'(mean[2]) + dh_c;
          phase <= 1'b1;
        end
        ST_T_LATM: begin
          amag <= product[31:0];
        end
        ST_T_LAT: begin
          dlat <= f_from_mag(div_num, aneg ^ tcos[32]);
        end
        ST_T_LON: begin
          mean[0] <= f_sat32(49'(mean[0]) + 49'(dlat));
          mean[1] <= f_sat32(49'(mean[1]) + 49'(dlon_c));
          mean[2] <= f_sat32(49'(mean[2]) + 49'(dh));
        end
        default: begin
        end
      endcase

      if (mul_go) begin
        mul_a  <= mul_a_in;
        mul_hi <= '0;
        mul_lo <= mul_b_in;
        cnt    <= '0;
      end
      if (div_go) begin
        div_num <= div_n_in;
        div_rem <= '0;
        div_den <= div_d_in;
        cnt     <= '0;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/pvft_check.sv
// Port-level checks for the pose tracker, bound to the top level.
`default_nettype none
module pvft_check (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input pvft_pkg::pvft_out_t out_data
);
  import pvft_pkg::*;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a held result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // an accepted transaction keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block idle right after an accepted transaction");

  // a new result appears only out of a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

endmodule

bind pose_variance_fusion_tracker pvft_check u_pvft_check (.*);
`default_nettype wire
